/* rtl/b64_pkg.sv */
// Shared types, constants and character decoding functions for the base64 stream decoder.
package b64_pkg;

  // Default number of entries in the job queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  // Widths of the accumulator and of one decoded job.
  localparam int unsigned SextetWidth = 6;
  localparam int unsigned StoreWidth  = 18;
  localparam int unsigned JobWidth    = 24;

  // Sextet counts that matter for flushing a partial quad.
  localparam logic [1:0] CountTwo   = 2'd2;
  localparam logic [1:0] CountThree = 2'd3;

  // One decoded job: up to three bytes, left aligned, and an end-of-string flag.
  typedef struct packed {
    logic [JobWidth-1:0] bytes;
    logic [1:0]          nbytes;
    logic                done;
  } job_t;

  // Result of classifying one character.
  typedef struct packed {
    logic                   ok;
    logic [SextetWidth-1:0] value;
  } sextet_t;

  // Maps an ASCII code to its six-bit value; ok is low for '=' and any other
  // character outside the alphabet.
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.value = SextetWidth'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.value = SextetWidth'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = SextetWidth'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.value = SextetWidth'(62);
    end else if (c == 8'h2f) begin
      r.value = SextetWidth'(63);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Builds the job for a partial quad: n sextets give n-1 bytes.
  function automatic job_t flush_job(input logic [StoreWidth-1:0] store,
                                     input logic [1:0] count);
    job_t j;
    j = '0;
    unique case (count)
      CountTwo: begin
        j.bytes  = {store[11:4], 16'h0000};
        j.nbytes = 2'd1;
      end
      CountThree: begin
        j.bytes  = {store[17:10], store[9:2], 8'h00};
        j.nbytes = 2'd2;
      end
      default: begin
        j = '0;
      end
    endcase
    return j;
  endfunction

endpackage

/* rtl/b64_in_if.sv */
// Input channel: one encoded character per request with an end-of-string flag.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

/* rtl/b64_out_if.sv */
// Output channel: one decoded byte or end marker per request.
interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output data_byte, output byte_valid, output run_last,
                  output string_done, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input run_last,
                input string_done, output ready);
endinterface

/* rtl/b64_front.sv */
// Front end: accepts characters, keeps the quad accumulator and forms decode jobs.
module b64_front (
  input  logic          clk,
  input  logic          rst,
  b64_in_if.sink        in_ch,
  input  logic          queue_full,
  output logic          push,
  output b64_pkg::job_t push_job
);
  import b64_pkg::*;

  logic [StoreWidth-1:0] sextet_store, sextet_store_next;
  logic [1:0]            sextet_count, sextet_count_next;
  logic                  halted, halted_next;
  logic                  accept;
  sextet_t               sx;
  job_t                  job;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the character and work out the job and the next accumulator.
  always_comb begin
    sx                = sextet_of(in_ch.char_code);
    job               = '0;
    sextet_store_next = sextet_store;
    sextet_count_next = sextet_count;
    halted_next       = halted;
    if (!halted) begin
      if (!sx.ok) begin
        job               = flush_job(sextet_store, sextet_count);
        sextet_store_next = '0;
        sextet_count_next = '0;
        halted_next       = 1'b1;
      end else if (sextet_count == CountThree) begin
        job.bytes         = {sextet_store, sx.value};
        job.nbytes        = 2'd3;
        sextet_store_next = '0;
        sextet_count_next = '0;
      end else begin
        sextet_store_next = {sextet_store[StoreWidth-SextetWidth-1:0], sx.value};
        sextet_count_next = sextet_count + 2'd1;
      end
    end
    // The last character flushes whatever is still pending and ends the string.
    if (in_ch.is_last) begin
      if (job.nbytes == 2'd0) begin
        job = flush_job(sextet_store_next, sextet_count_next);
      end
      job.done          = 1'b1;
      sextet_store_next = '0;
      sextet_count_next = '0;
      halted_next       = 1'b0;
    end
    push     = accept && (job.nbytes != 2'd0 || in_ch.is_last);
    push_job = job;
  end

  // Accumulator state moves only on an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_store <= '0;
      sextet_count <= '0;
      halted       <= 1'b0;
    end else if (accept) begin
      sextet_store <= sextet_store_next;
      sextet_count <= sextet_count_next;
      halted       <= halted_next;
    end
  end

endmodule

/* rtl/b64_queue.sv */
// Small first-in first-out queue of decode jobs between front and back.
module b64_queue #(
  parameter int unsigned DEPTH = b64_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b64_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output b64_pkg::job_t head_job
);
  import b64_pkg::*;

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  job_t                entries [DEPTH];
  logic [PtrWidth-1:0] wr_ptr, rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push, do_pop;

  assign full      = (count == CntWidth'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_job  = entries[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/b64_back.sv */
// Back end: takes jobs from the queue and sends their bytes out one per request.
module b64_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_avail,
  input  b64_pkg::job_t head_job,
  output logic          pop,
  b64_out_if.source     out_ch
);
  import b64_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       fire;
  logic       last_of_job;
  logic       load_slot;
  logic [7:0] sel_byte;

  // Pick the byte under the index; the job is left aligned.
  always_comb begin
    unique case (idx)
      2'd0:    sel_byte = cur.bytes[23:16];
      2'd1:    sel_byte = cur.bytes[15:8];
      default: sel_byte = cur.bytes[7:0];
    endcase
  end

  assign last_of_job = (cur.nbytes == 2'd0) || (idx == cur.nbytes - 2'd1);
  assign fire        = out_ch.valid && out_ch.ready;
  assign load_slot   = !cur_valid || (fire && last_of_job);
  assign pop         = load_slot && job_avail;

  assign out_ch.valid       = cur_valid;
  assign out_ch.byte_valid  = (cur.nbytes != 2'd0);
  assign out_ch.data_byte   = (cur.nbytes != 2'd0) ? sel_byte : 8'h00;
  assign out_ch.run_last    = last_of_job;
  assign out_ch.string_done = cur.done && last_of_job;

  // Job payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

  // Slot occupancy and byte index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load_slot) begin
      cur_valid <= job_avail;
      idx       <= '0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

/* rtl/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder: front end, job queue and back end.
//
//   Channel   Direction  Carries
//   in_ch     sink       char_code[7:0], is_last
//   out_ch    source     data_byte[7:0], byte_valid, run_last, string_done
//
// A character is accepted in any cycle in which the job queue has room, so one
// character per cycle is taken; its results leave one per cycle, while out_ch is
// ready, from the back end's job register; a full quad of four characters yields
// three bytes. A job passes through the queue and then the back end's job register.
// Reset is synchronous and clears the accumulator, the queue and the back end.
// A stall on out_ch fills the queue and then holds in_ch.ready low.
module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = b64_pkg::QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  b64_in_if.sink    in_ch,
  b64_out_if.source out_ch
);
  import b64_pkg::*;

  logic push, queue_full, pop, job_avail;
  job_t push_job, head_job;

  // Character intake and quad accumulation.
  b64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Job buffer between the two halves.
  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (job_avail),
    .head_job  (head_job)
  );

  // Byte serializer.
  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (job_avail),
    .head_job  (head_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

/* tb/sv/b64_decode_checker.sv */
// Checker for the base64 stream decoder: predicts decoded results and compares them.
module b64_decode_checker (
  input  logic clk,
  input  logic rst,
  b64_in_if    in_ch,
  b64_out_if   out_ch,
  output int   errors,
  output int   waiting,
  output int   strings_seen,
  output int   bytes_seen,
  output int   markers_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
  } dec_result_t;

  // Expected decoder results, oldest first.
  dec_result_t decoded_q[$];
  // Results caused by the character being decoded now.
  dec_result_t batch[$];

  // Decoder state as the predictor sees it.
  logic [17:0] quad_bits;
  logic [1:0]  quad_fill;
  logic        stopped;

  int err_count;
  int done_count;
  int byte_count;
  int marker_count;

  assign errors       = err_count;
  assign waiting      = decoded_q.size();
  assign strings_seen = done_count;
  assign bytes_seen   = byte_count;
  assign markers_seen = marker_count;

  initial begin
    quad_bits = '0;
    quad_fill = '0;
    stopped   = 1'b0;
  end

  // Returns 1 and the six-bit value for an alphabet character, 0 for a halt character.
  function automatic logic sextet_value(input logic [7:0] c, output logic [5:0] v);
    v = '0;
    case (c) inside
      [8'h41:8'h5a]: v = 6'(c - 8'h41);
      [8'h61:8'h7a]: v = 6'(c - 8'h47);
      [8'h30:8'h39]: v = 6'(c + 8'h04);
      8'h2b:         v = 6'd62;
      8'h2f:         v = 6'd63;
      default:       return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    dec_result_t r;
    r = '{data_byte: b, byte_valid: 1'b1, run_last: 1'b0, string_done: 1'b0};
    batch = {batch, r};
  endfunction

  // A partial quad of n sextets yields n-1 bytes; the accumulator empties.
  function automatic void flush_quad();
    if (quad_fill == 2'd2) begin
      push_byte(quad_bits[11:4]);
    end else if (quad_fill == 2'd3) begin
      push_byte(quad_bits[17:10]);
      push_byte(quad_bits[9:2]);
    end
    quad_bits = '0;
    quad_fill = '0;
  endfunction

  // Works out the results of one accepted character and queues them.
  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic [5:0]  v;
    logic [23:0] word;
    dec_result_t marker;
    batch = {};
    if (!stopped) begin
      if (!sextet_value(c, v)) begin
        flush_quad();
        stopped = 1'b1;
      end else if (quad_fill == 2'd3) begin
        word = {quad_bits, v};
        push_byte(word[23:16]);
        push_byte(word[15:8]);
        push_byte(word[7:0]);
        quad_bits = '0;
        quad_fill = '0;
      end else begin
        quad_bits = {quad_bits[11:0], v};
        quad_fill = quad_fill + 2'd1;
      end
    end
    // The end of a string always closes with a done result, a bare marker if need be.
    if (last) begin
      flush_quad();
      if (batch.size() == 0) begin
        marker = '{data_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b0, string_done: 1'b0};
        batch  = {batch, marker};
      end
      batch[batch.size()-1].string_done = 1'b1;
      stopped = 1'b0;
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].run_last = 1'b1;
    end
    decoded_q = {decoded_q, batch};
  endfunction

  function automatic void flag(input string what, input dec_result_t want,
                               input dec_result_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s: expected byte %02h valid %0b run_last %0b done %0b",
               $time, what, want.data_byte, want.byte_valid, want.run_last,
               want.string_done);
      $display("    got byte %02h valid %0b run_last %0b done %0b",
               got.data_byte, got.byte_valid, got.run_last, got.string_done);
    end
  endfunction

  // Both channels are sampled at the falling edge, where they are stable before
  // the rising edge that completes the request.
  always @(negedge clk) begin
    dec_result_t got;
    dec_result_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_char(in_ch.char_code, in_ch.is_last);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{data_byte: out_ch.data_byte, byte_valid: out_ch.byte_valid,
                run_last: out_ch.run_last, string_done: out_ch.string_done};
        if (decoded_q.size() == 0) begin
          flag("result with nothing expected", '0, got);
        end else begin
          want = decoded_q.pop_front();
          if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
              got.run_last !== want.run_last || got.string_done !== want.string_done) begin
            flag("result mismatch", want, got);
          end else begin
            if (want.byte_valid) byte_count++;
            else marker_count++;
            if (want.string_done) done_count++;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/base64_stream_decoder_tb.sv */
// Top of the base64 stream decoder testbench: clock, reset, stimulus and verdict.
module base64_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] PadChar = 8'h3d;
  localparam int unsigned IdlePercent = 24;
  localparam int unsigned CharBudget = 210;

  typedef enum int unsigned {TailNone, TailPadOne, TailPadTwo, TailCut, TailJunk} tail_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit steady = 1'b0;
  int unsigned sent = 0;

  int errors;
  int waiting;
  int strings_seen;
  int bytes_seen;
  int markers_seen;

  b64_in_if  in_ch();
  b64_out_if out_ch();

  base64_stream_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b64_decode_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .errors       (errors),
    .waiting      (waiting),
    .strings_seen (strings_seen),
    .bytes_seen   (bytes_seen),
    .markers_seen (markers_seen)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random except in the steady stretch.
  always @(posedge clk) begin
    out_ch.ready <= rst ? 1'b0 : (steady || $urandom_range(99) >= IdlePercent);
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("base64_stream_decoder_tb NOT OK");
    $finish;
  end

  // Character of the base64 alphabet with the given six-bit value.
  function automatic logic [7:0] b64_char(input int unsigned idx);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    return (idx == 62) ? 8'h2b : 8'h2f;
  endfunction

  // Offers one character, with random idle cycles first, until it is taken.
  task automatic send_char(input logic [7:0] c, input logic last);
    logic took;
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.is_last   <= last;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic send_line(input logic [7:0] line[$]);
    foreach (line[i]) send_char(line[i], i == line.size() - 1);
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && i == s.len() - 1);
  endtask

  initial begin
    logic [7:0] line[$];
    logic [7:0] ch;
    tail_kind_e tail;
    in_ch.valid     = 1'b0;
    in_ch.char_code = 8'h00;
    in_ch.is_last   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: a quad closed by the last character, a lone character
    // after a full quad, double padding, junk bytes at both ends of the range,
    // a halt byte as last character, a lone pad and a two-character tail.
    send_text("TWFu", 1'b1);
    send_text("/+z0a", 1'b1);
    send_text("TQ==", 1'b1);
    send_char(8'hff, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h00, 1'b1);
    send_text("Zm9", 1'b0);
    send_char(8'h80, 1'b1);
    send_text("=", 1'b1);
    send_text("9a", 1'b1);

    // Random strings: mostly well-formed base64, the rest noise.
    while (sent < CharBudget) begin
      steady = (sent >= 100 && sent < 150);
      line = {};
      if ($urandom_range(9) < 7) begin
        repeat (4 * $urandom_range(3)) line = {line, b64_char($urandom_range(63))};
        tail = tail_kind_e'($urandom_range(4));
        case (tail)
          TailPadOne: begin
            repeat (3) line = {line, b64_char($urandom_range(63))};
            line = {line, PadChar};
          end
          TailPadTwo: begin
            repeat (2) line = {line, b64_char($urandom_range(63))};
            line = {line, PadChar};
            line = {line, PadChar};
          end
          TailCut: begin
            repeat ($urandom_range(1, 3)) line = {line, b64_char($urandom_range(63))};
          end
          TailJunk: begin
            line = {line, PadChar};
            repeat ($urandom_range(1, 4)) line = {line, 8'($urandom_range(255))};
          end
          default: begin
          end
        endcase
        if (line.size() == 0) line = {line, b64_char($urandom_range(63))};
      end else begin
        repeat ($urandom_range(1, 8)) begin
          ch   = $urandom_range(1) ? b64_char($urandom_range(63)) : 8'($urandom_range(255));
          line = {line, ch};
        end
      end
      send_line(line);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain the expected results, then watch a little longer for strays.
    while (waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters; checked %0d decoded strings, %0d bytes, %0d end markers.",
             sent, strings_seen, bytes_seen, markers_seen);
    if (errors == 0) begin
      $display("base64_stream_decoder_tb OK");
    end else begin
      $display("%0d mismatches.", errors);
      $display("base64_stream_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/b64_pkg.sv
rtl/b64_in_if.sv
rtl/b64_out_if.sv
rtl/b64_front.sv
rtl/b64_queue.sv
rtl/b64_back.sv
rtl/base64_stream_decoder.sv
tb/sv/b64_decode_checker.sv
tb/sv/base64_stream_decoder_tb.sv
